// File: design/bsse_pkg.sv
// Shared constants, types and command/status structs for the bounded set store engine.
`timescale 1ns / 1ps

package bsse_pkg;

    localparam int NUM_SETS    = 16;
    localparam int SET_CAP     = 32;
    localparam int VALUE_WIDTH = 32;

    localparam int SET_W    = $clog2(NUM_SETS);
    localparam int POS_W    = $clog2(SET_CAP);
    localparam int LEN_W    = $clog2(SET_CAP + 1);
    localparam int SIU_W    = $clog2(NUM_SETS + 1);
    localparam int CNT_W    = (LEN_W > SIU_W) ? LEN_W : SIU_W;
    localparam int ADDR_W   = SET_W + POS_W;
    localparam int DEPTH    = NUM_SETS * SET_CAP;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATE = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_UNION  = 3'd3,
        KIND_INTER  = 3'd4,
        KIND_SEARCH = 3'd5,
        KIND_READ   = 3'd6
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 4'd0,
        ST_NO_ROOM   = 4'd1,
        ST_BAD_SET   = 4'd2,
        ST_ZERO      = 4'd3,
        ST_DUP       = 4'd4,
        ST_FULL      = 4'd5,
        ST_FEW       = 4'd6,
        ST_LARGE     = 4'd7,
        ST_NOT_FOUND = 4'd8
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LEN_A, S_LEN_B, S_DECIDE,
        S_INS_RD, S_INS_CMP, S_INS_WR,
        S_RM_RD, S_RM_WR, S_RM_FIN,
        S_CP_RD, S_CP_WR,
        S_B_CHK, S_B_RD, S_B_HOLD, S_SC_RD, S_SC_CMP, S_B_DEC, S_COMMIT,
        S_SR_SET, S_SR_RD, S_SR_CMP, S_SR_FIN,
        S_RD_RD, S_RD_EM
    } state_t;

    // element memory read address forms: row / position
    typedef enum logic [1:0] {RS_AJ, RS_BI, RS_IJ, RS_I1J} rsel_t;
    // element memory write address forms
    typedef enum logic [1:0] {WS_ALEN, WS_NEWN, WS_IJ} wsel_t;
    typedef enum logic [1:0] {WD_VAL, WD_RD, WD_HOLD} wdat_t;
    typedef enum logic [1:0] {LA_A, LA_B, LA_I} lsel_t;
    typedef enum logic [2:0] {IX_ZERO, IX_A, IX_BAD, IX_SIU, IX_PEND} idx_t;
    typedef enum logic [2:0] {LN_ZERO, LN_LA, LN_LA_INC, LN_N, LN_PEND} lsrc_t;

    typedef struct packed {
        logic    load;
        logic    la_ld;
        logic    lb_ld;
        lsel_t   len_addr;
        logic    rd_en;
        rsel_t   rd_sel;
        logic    wr_en;
        wsel_t   wr_sel;
        wdat_t   wr_dat;
        logic    create;
        logic    ins_len;
        logic    remove;
        logic    commit;
        logic    i_set_a;
        logic    i_inc;
        logic    j_inc;
        logic    j_clr;
        logic    n_inc;
        logic    hold_ld;
        logic    found_set;
        logic    found_clr;
        logic    pend_ld;
        logic    emit;
        status_t em_status;
        idx_t    em_idx;
        lsrc_t   em_len;
        logic    em_elem;
        logic    em_last;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  full;
        logic  few;
        logic  bad_a;
        logic  bad_b;
        logic  la_full;
        logic  la_zero;
        logic  zero;
        logic  i_end_b;
        logic  j_last_a;
        logic  j_last_s;
        logic  jcap_last;
        logic  s_len_zero;
        logic  i_end_siu;
        logic  i_rm_last;
        logic  a_is_last;
        logic  match_val;
        logic  match_hold;
        logic  n_full;
        logic  found;
        logic  pend_valid;
        logic  out_free;
    } sts_t;

endpackage

// File: design/bounded_set_store_engine_unit.sv
// Top level of the bounded set store engine: sequencer plus datapath.
`timescale 1ns / 1ps

//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+-------------------------------------------
//  s_       | in        | s_valid / s_ready | s_kind, s_set_a, s_set_b, s_value
//  m_       | out       | m_valid / m_ready | m_status, m_set_index, m_element,
//           |           |                   | m_length, m_last
//
//  One request at a time. The lengths of sets a and b are fetched first; then insert scans
//  set a for a duplicate before writing, read returns set a element by element, remove
//  copies every later set down one row, search probes the stored elements set by set, and
//  union/intersection scan set a for each element of b, every element read going through
//  the single read port of the element memory.
//  Reset (aresetn low, synchronous) empties the store; element rows are never cleared.
//  A stalled result holds in the output register and stalls the sequencer at its next result.

module bounded_set_store_engine_unit (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [bsse_pkg::KIND_W-1:0]             s_kind,
    input  logic [bsse_pkg::SET_W-1:0]              s_set_a,
    input  logic [bsse_pkg::SET_W-1:0]              s_set_b,
    input  logic signed [bsse_pkg::VALUE_WIDTH-1:0] s_value,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [bsse_pkg::STATUS_W-1:0]           m_status,
    output logic [bsse_pkg::SET_W-1:0]              m_set_index,
    output logic signed [bsse_pkg::VALUE_WIDTH-1:0] m_element,
    output logic [bsse_pkg::LEN_W-1:0]              m_length,
    output logic                                    m_last
);

    // command and status between sequencer and datapath
    bsse_pkg::cmd_t cmd;
    bsse_pkg::sts_t sts;

    // sequencer: walks each request through its scan and copy loops
    bsse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: holds the request, length table, element memory and result register
    bsse_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_kind      (s_kind),
        .s_set_a     (s_set_a),
        .s_set_b     (s_set_b),
        .s_value     (s_value),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_set_index (m_set_index),
        .m_element   (m_element),
        .m_length    (m_length),
        .m_last      (m_last)
    );

endmodule

// File: design/bsse_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bsse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/bsse_ctrl.sv
// Sequencer state machine for the bounded set store engine.
`timescale 1ns / 1ps

module bsse_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bsse_pkg::sts_t sts,
    output bsse_pkg::cmd_t cmd
);

    bsse_pkg::state_t state_reg, state_next;

    function automatic bsse_pkg::cmd_t em(bsse_pkg::cmd_t c, bsse_pkg::status_t s,
                                          bsse_pkg::idx_t x, bsse_pkg::lsrc_t l,
                                          logic last);
        bsse_pkg::cmd_t r;
        r           = c;
        r.emit      = 1'b1;
        r.em_status = s;
        r.em_idx    = x;
        r.em_len    = l;
        r.em_last   = last;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bsse_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == bsse_pkg::S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            bsse_pkg::S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = bsse_pkg::S_LEN_A;
                end
            end
            bsse_pkg::S_LEN_A: begin
                cmd.len_addr = bsse_pkg::LA_A;
                cmd.la_ld    = 1'b1;
                state_next   = bsse_pkg::S_LEN_B;
            end
            bsse_pkg::S_LEN_B: begin
                cmd.len_addr = bsse_pkg::LA_B;
                cmd.lb_ld    = 1'b1;
                state_next   = bsse_pkg::S_DECIDE;
            end
            bsse_pkg::S_DECIDE: begin
                unique case (sts.kind)
                    bsse_pkg::KIND_CREATE: begin
                        if (sts.out_free) begin
                            if (sts.full) begin
                                cmd = em(cmd, bsse_pkg::ST_NO_ROOM, bsse_pkg::IX_ZERO,
                                         bsse_pkg::LN_ZERO, 1'b1);
                            end else begin
                                cmd = em(cmd, bsse_pkg::ST_OK, bsse_pkg::IX_SIU,
                                         bsse_pkg::LN_ZERO, 1'b1);
                                cmd.create = 1'b1;
                            end
                            state_next = bsse_pkg::S_IDLE;
                        end
                    end
                    bsse_pkg::KIND_INSERT: begin
                        priority if (sts.bad_a || sts.la_full || sts.zero) begin
                            if (sts.out_free) begin
                                priority if (sts.bad_a) begin
                                    cmd = em(cmd, bsse_pkg::ST_BAD_SET, bsse_pkg::IX_A,
                                             bsse_pkg::LN_ZERO, 1'b1);
                                end else if (sts.la_full) begin
                                    cmd = em(cmd, bsse_pkg::ST_FULL, bsse_pkg::IX_A,
                                             bsse_pkg::LN_LA, 1'b1);
                                end else begin
                                    cmd = em(cmd, bsse_pkg::ST_ZERO, bsse_pkg::IX_A,
                                             bsse_pkg::LN_LA, 1'b1);
                                end
                                state_next = bsse_pkg::S_IDLE;
                            end
                        end else if (sts.la_zero) begin
                            state_next = bsse_pkg::S_INS_WR;
                        end else begin
                            state_next = bsse_pkg::S_INS_RD;
                        end
                    end
                    bsse_pkg::KIND_REMOVE: begin
                        priority if (sts.bad_a) begin
                            if (sts.out_free) begin
                                cmd = em(cmd, bsse_pkg::ST_BAD_SET, bsse_pkg::IX_A,
                                         bsse_pkg::LN_ZERO, 1'b1);
                                state_next = bsse_pkg::S_IDLE;
                            end
                        end else if (sts.a_is_last) begin
                            state_next = bsse_pkg::S_RM_FIN;
                        end else begin
                            cmd.i_set_a = 1'b1;
                            cmd.j_clr   = 1'b1;
                            state_next  = bsse_pkg::S_RM_RD;
                        end
                    end
                    bsse_pkg::KIND_UNION, bsse_pkg::KIND_INTER: begin
                        priority if (sts.full || sts.few || sts.bad_a || sts.bad_b) begin
                            if (sts.out_free) begin
                                priority if (sts.full) begin
                                    cmd = em(cmd, bsse_pkg::ST_NO_ROOM, bsse_pkg::IX_ZERO,
                                             bsse_pkg::LN_ZERO, 1'b1);
                                end else if (sts.few) begin
                                    cmd = em(cmd, bsse_pkg::ST_FEW, bsse_pkg::IX_ZERO,
                                             bsse_pkg::LN_ZERO, 1'b1);
                                end else begin
                                    cmd = em(cmd, bsse_pkg::ST_BAD_SET, bsse_pkg::IX_BAD,
                                             bsse_pkg::LN_ZERO, 1'b1);
                                end
                                state_next = bsse_pkg::S_IDLE;
                            end
                        end else if (sts.kind == bsse_pkg::KIND_UNION && !sts.la_zero) begin
                            state_next = bsse_pkg::S_CP_RD;
                        end else begin
                            state_next = bsse_pkg::S_B_CHK;
                        end
                    end
                    bsse_pkg::KIND_SEARCH: begin
                        state_next = sts.zero ? bsse_pkg::S_SR_FIN : bsse_pkg::S_SR_SET;
                    end
                    bsse_pkg::KIND_READ: begin
                        priority if (sts.bad_a || sts.la_zero) begin
                            if (sts.out_free) begin
                                if (sts.bad_a) begin
                                    cmd = em(cmd, bsse_pkg::ST_BAD_SET, bsse_pkg::IX_A,
                                             bsse_pkg::LN_ZERO, 1'b1);
                                end else begin
                                    cmd = em(cmd, bsse_pkg::ST_OK, bsse_pkg::IX_A,
                                             bsse_pkg::LN_ZERO, 1'b1);
                                end
                                state_next = bsse_pkg::S_IDLE;
                            end
                        end else begin
                            state_next = bsse_pkg::S_RD_RD;
                        end
                    end
                    default: begin
                        state_next = bsse_pkg::S_IDLE;
                    end
                endcase
            end
            bsse_pkg::S_INS_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bsse_pkg::RS_AJ;
                state_next = bsse_pkg::S_INS_CMP;
            end
            bsse_pkg::S_INS_CMP: begin
                if (sts.match_val) begin
                    if (sts.out_free) begin
                        cmd = em(cmd, bsse_pkg::ST_DUP, bsse_pkg::IX_A,
                                 bsse_pkg::LN_LA, 1'b1);
                        state_next = bsse_pkg::S_IDLE;
                    end
                end else begin
                    cmd.j_inc  = 1'b1;
                    state_next = sts.j_last_a ? bsse_pkg::S_INS_WR : bsse_pkg::S_INS_RD;
                end
            end
            bsse_pkg::S_INS_WR: begin
                if (sts.out_free) begin
                    cmd = em(cmd, bsse_pkg::ST_OK, bsse_pkg::IX_A,
                             bsse_pkg::LN_LA_INC, 1'b1);
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = bsse_pkg::WS_ALEN;
                    cmd.wr_dat  = bsse_pkg::WD_VAL;
                    cmd.ins_len = 1'b1;
                    state_next  = bsse_pkg::S_IDLE;
                end
            end
            bsse_pkg::S_RM_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bsse_pkg::RS_I1J;
                state_next = bsse_pkg::S_RM_WR;
            end
            bsse_pkg::S_RM_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = bsse_pkg::WS_IJ;
                cmd.wr_dat = bsse_pkg::WD_RD;
                if (sts.jcap_last) begin
                    cmd.j_clr  = 1'b1;
                    cmd.i_inc  = 1'b1;
                    state_next = sts.i_rm_last ? bsse_pkg::S_RM_FIN : bsse_pkg::S_RM_RD;
                end else begin
                    cmd.j_inc  = 1'b1;
                    state_next = bsse_pkg::S_RM_RD;
                end
            end
            bsse_pkg::S_RM_FIN: begin
                if (sts.out_free) begin
                    cmd = em(cmd, bsse_pkg::ST_OK, bsse_pkg::IX_A, bsse_pkg::LN_LA, 1'b1);
                    cmd.remove = 1'b1;
                    state_next = bsse_pkg::S_IDLE;
                end
            end
            bsse_pkg::S_CP_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bsse_pkg::RS_AJ;
                state_next = bsse_pkg::S_CP_WR;
            end
            bsse_pkg::S_CP_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = bsse_pkg::WS_NEWN;
                cmd.wr_dat = bsse_pkg::WD_RD;
                cmd.n_inc  = 1'b1;
                if (sts.j_last_a) begin
                    cmd.j_clr  = 1'b1;
                    state_next = bsse_pkg::S_B_CHK;
                end else begin
                    cmd.j_inc  = 1'b1;
                    state_next = bsse_pkg::S_CP_RD;
                end
            end
            bsse_pkg::S_B_CHK: begin
                state_next = sts.i_end_b ? bsse_pkg::S_COMMIT : bsse_pkg::S_B_RD;
            end
            bsse_pkg::S_B_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bsse_pkg::RS_BI;
                state_next = bsse_pkg::S_B_HOLD;
            end
            bsse_pkg::S_B_HOLD: begin
                cmd.hold_ld   = 1'b1;
                cmd.found_clr = 1'b1;
                cmd.j_clr     = 1'b1;
                state_next    = sts.la_zero ? bsse_pkg::S_B_DEC : bsse_pkg::S_SC_RD;
            end
            bsse_pkg::S_SC_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bsse_pkg::RS_AJ;
                state_next = bsse_pkg::S_SC_CMP;
            end
            bsse_pkg::S_SC_CMP: begin
                if (sts.match_hold) begin
                    cmd.found_set = 1'b1;
                    state_next    = bsse_pkg::S_B_DEC;
                end else begin
                    cmd.j_inc  = 1'b1;
                    state_next = sts.j_last_a ? bsse_pkg::S_B_DEC : bsse_pkg::S_SC_RD;
                end
            end
            bsse_pkg::S_B_DEC: begin
                if (sts.kind == bsse_pkg::KIND_UNION) begin
                    priority if (sts.found) begin
                        cmd.i_inc  = 1'b1;
                        state_next = bsse_pkg::S_B_CHK;
                    end else if (sts.n_full) begin
                        if (sts.out_free) begin
                            cmd = em(cmd, bsse_pkg::ST_LARGE, bsse_pkg::IX_ZERO,
                                     bsse_pkg::LN_ZERO, 1'b1);
                            state_next = bsse_pkg::S_IDLE;
                        end
                    end else begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = bsse_pkg::WS_NEWN;
                        cmd.wr_dat = bsse_pkg::WD_HOLD;
                        cmd.n_inc  = 1'b1;
                        cmd.i_inc  = 1'b1;
                        state_next = bsse_pkg::S_B_CHK;
                    end
                end else begin
                    if (sts.found) begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = bsse_pkg::WS_NEWN;
                        cmd.wr_dat = bsse_pkg::WD_HOLD;
                        cmd.n_inc  = 1'b1;
                    end
                    cmd.i_inc  = 1'b1;
                    state_next = bsse_pkg::S_B_CHK;
                end
            end
            bsse_pkg::S_COMMIT: begin
                if (sts.out_free) begin
                    cmd = em(cmd, bsse_pkg::ST_OK, bsse_pkg::IX_SIU, bsse_pkg::LN_N, 1'b1);
                    cmd.commit = 1'b1;
                    state_next = bsse_pkg::S_IDLE;
                end
            end
            bsse_pkg::S_SR_SET: begin
                cmd.len_addr = bsse_pkg::LA_I;
                priority if (sts.i_end_siu) begin
                    state_next = bsse_pkg::S_SR_FIN;
                end else if (sts.s_len_zero) begin
                    cmd.i_inc = 1'b1;
                end else begin
                    cmd.j_clr  = 1'b1;
                    state_next = bsse_pkg::S_SR_RD;
                end
            end
            bsse_pkg::S_SR_RD: begin
                cmd.len_addr = bsse_pkg::LA_I;
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = bsse_pkg::RS_IJ;
                state_next   = bsse_pkg::S_SR_CMP;
            end
            bsse_pkg::S_SR_CMP: begin
                cmd.len_addr = bsse_pkg::LA_I;
                if (sts.match_val) begin
                    if (!sts.pend_valid || sts.out_free) begin
                        if (sts.pend_valid) begin
                            cmd = em(cmd, bsse_pkg::ST_OK, bsse_pkg::IX_PEND,
                                     bsse_pkg::LN_PEND, 1'b0);
                        end
                        cmd.pend_ld = 1'b1;
                        cmd.i_inc   = 1'b1;
                        state_next  = bsse_pkg::S_SR_SET;
                    end
                end else if (sts.j_last_s) begin
                    cmd.i_inc  = 1'b1;
                    state_next = bsse_pkg::S_SR_SET;
                end else begin
                    cmd.j_inc  = 1'b1;
                    state_next = bsse_pkg::S_SR_RD;
                end
            end
            bsse_pkg::S_SR_FIN: begin
                if (sts.out_free) begin
                    if (sts.pend_valid) begin
                        cmd = em(cmd, bsse_pkg::ST_OK, bsse_pkg::IX_PEND,
                                 bsse_pkg::LN_PEND, 1'b1);
                    end else begin
                        cmd = em(cmd, bsse_pkg::ST_NOT_FOUND, bsse_pkg::IX_ZERO,
                                 bsse_pkg::LN_ZERO, 1'b1);
                    end
                    state_next = bsse_pkg::S_IDLE;
                end
            end
            bsse_pkg::S_RD_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bsse_pkg::RS_AJ;
                state_next = bsse_pkg::S_RD_EM;
            end
            bsse_pkg::S_RD_EM: begin
                if (sts.out_free) begin
                    cmd = em(cmd, bsse_pkg::ST_OK, bsse_pkg::IX_A, bsse_pkg::LN_LA,
                             sts.j_last_a);
                    cmd.em_elem = 1'b1;
                    cmd.j_inc   = 1'b1;
                    state_next  = sts.j_last_a ? bsse_pkg::S_IDLE : bsse_pkg::S_RD_RD;
                end
            end
            default: begin
                state_next = bsse_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == bsse_pkg::S_LEN_A))
        else $error("accepted request did not start decoding");
    a_emit_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("result issued while output register is occupied");
    a_no_write_in_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bsse_pkg::S_IDLE) |-> !cmd.wr_en)
        else $error("element memory written while idle");
`endif

endmodule

// File: design/bsse_dp.sv
// Datapath: request registers, set lengths, counters, element memory and output register.
`timescale 1ns / 1ps

module bsse_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [bsse_pkg::KIND_W-1:0]         s_kind,
    input  logic [bsse_pkg::SET_W-1:0]          s_set_a,
    input  logic [bsse_pkg::SET_W-1:0]          s_set_b,
    input  logic signed [bsse_pkg::VALUE_WIDTH-1:0] s_value,
    input  bsse_pkg::cmd_t                      cmd,
    output bsse_pkg::sts_t                      sts,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bsse_pkg::STATUS_W-1:0]       m_status,
    output logic [bsse_pkg::SET_W-1:0]          m_set_index,
    output logic signed [bsse_pkg::VALUE_WIDTH-1:0] m_element,
    output logic [bsse_pkg::LEN_W-1:0]          m_length,
    output logic                                m_last
);

    localparam int CW1 = bsse_pkg::CNT_W + 1;

    bsse_pkg::kind_t                   kind_reg;
    logic [bsse_pkg::SET_W-1:0]        a_reg, b_reg;
    logic [bsse_pkg::VALUE_WIDTH-1:0]  val_reg, hold_reg;
    logic [bsse_pkg::SIU_W-1:0]        siu_reg, siu_next;
    logic [bsse_pkg::LEN_W-1:0]        len_reg [bsse_pkg::NUM_SETS];
    logic [bsse_pkg::LEN_W-1:0]        la_reg, lb_reg, n_reg;
    logic [bsse_pkg::CNT_W-1:0]        i_reg, j_reg, i_plus1;
    logic                              found_reg, pend_valid_reg;
    logic [bsse_pkg::SET_W-1:0]        pend_idx_reg;
    logic [bsse_pkg::LEN_W-1:0]        pend_len_reg;

    logic                              m_valid_reg, m_last_reg;
    logic [bsse_pkg::STATUS_W-1:0]     m_status_reg;
    logic [bsse_pkg::SET_W-1:0]        m_idx_reg;
    logic [bsse_pkg::VALUE_WIDTH-1:0]  m_elem_reg;
    logic [bsse_pkg::LEN_W-1:0]        m_len_reg;

    logic [bsse_pkg::SET_W-1:0]        len_idx;
    logic [bsse_pkg::LEN_W-1:0]        len_rd;
    logic [bsse_pkg::ADDR_W-1:0]       raddr, waddr;
    logic [bsse_pkg::VALUE_WIDTH-1:0]  wdata, rdata;
    logic                              out_free;
    logic [bsse_pkg::SET_W-1:0]        em_idx;
    logic [bsse_pkg::LEN_W-1:0]        em_len;

    assign out_free = !m_valid_reg || m_ready;
    assign i_plus1  = i_reg + 1'b1;

    // one shared read port onto the length table
    always_comb begin
        unique case (cmd.len_addr)
            bsse_pkg::LA_A: len_idx = a_reg;
            bsse_pkg::LA_B: len_idx = b_reg;
            bsse_pkg::LA_I: len_idx = i_reg[bsse_pkg::SET_W-1:0];
            default:        len_idx = a_reg;
        endcase
    end
    assign len_rd = len_reg[len_idx];

    always_comb begin
        unique case (cmd.rd_sel)
            bsse_pkg::RS_AJ:  raddr = {a_reg, j_reg[bsse_pkg::POS_W-1:0]};
            bsse_pkg::RS_BI:  raddr = {b_reg, i_reg[bsse_pkg::POS_W-1:0]};
            bsse_pkg::RS_IJ:  raddr = {i_reg[bsse_pkg::SET_W-1:0], j_reg[bsse_pkg::POS_W-1:0]};
            bsse_pkg::RS_I1J: raddr = {i_plus1[bsse_pkg::SET_W-1:0],
                                       j_reg[bsse_pkg::POS_W-1:0]};
            default:          raddr = {a_reg, j_reg[bsse_pkg::POS_W-1:0]};
        endcase
        unique case (cmd.wr_sel)
            bsse_pkg::WS_ALEN: waddr = {a_reg, la_reg[bsse_pkg::POS_W-1:0]};
            bsse_pkg::WS_NEWN: waddr = {siu_reg[bsse_pkg::SET_W-1:0],
                                        n_reg[bsse_pkg::POS_W-1:0]};
            bsse_pkg::WS_IJ:   waddr = {i_reg[bsse_pkg::SET_W-1:0],
                                        j_reg[bsse_pkg::POS_W-1:0]};
            default:           waddr = {a_reg, la_reg[bsse_pkg::POS_W-1:0]};
        endcase
        unique case (cmd.wr_dat)
            bsse_pkg::WD_VAL:  wdata = val_reg;
            bsse_pkg::WD_RD:   wdata = rdata;
            bsse_pkg::WD_HOLD: wdata = hold_reg;
            default:           wdata = val_reg;
        endcase
    end

    bsse_ram #(
        .WIDTH (bsse_pkg::VALUE_WIDTH),
        .DEPTH (bsse_pkg::DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    // status toward the sequencer
    always_comb begin
        sts.kind       = kind_reg;
        sts.full       = siu_reg >= bsse_pkg::SIU_W'(bsse_pkg::NUM_SETS);
        sts.few        = siu_reg < bsse_pkg::SIU_W'(2);
        sts.bad_a      = bsse_pkg::SIU_W'(a_reg) >= siu_reg;
        sts.bad_b      = bsse_pkg::SIU_W'(b_reg) >= siu_reg;
        sts.la_full    = la_reg >= bsse_pkg::LEN_W'(bsse_pkg::SET_CAP);
        sts.la_zero    = la_reg == '0;
        sts.zero       = val_reg == '0;
        sts.i_end_b    = CW1'(i_reg) >= CW1'(lb_reg);
        sts.j_last_a   = CW1'(j_reg) + CW1'(1) >= CW1'(la_reg);
        sts.j_last_s   = CW1'(j_reg) + CW1'(1) >= CW1'(len_rd);
        sts.jcap_last  = CW1'(j_reg) == CW1'(bsse_pkg::SET_CAP - 1);
        sts.s_len_zero = len_rd == '0;
        sts.i_end_siu  = CW1'(i_reg) >= CW1'(siu_reg);
        sts.i_rm_last  = CW1'(i_reg) + CW1'(2) >= CW1'(siu_reg);
        sts.a_is_last  = CW1'(a_reg) + CW1'(1) >= CW1'(siu_reg);
        sts.match_val  = rdata == val_reg;
        sts.match_hold = rdata == hold_reg;
        sts.n_full     = n_reg >= bsse_pkg::LEN_W'(bsse_pkg::SET_CAP);
        sts.found      = found_reg;
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = out_free;
    end

    always_comb begin
        siu_next = siu_reg;
        if (cmd.create || cmd.commit) begin
            siu_next = siu_reg + 1'b1;
        end else if (cmd.remove) begin
            siu_next = siu_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            siu_reg        <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            for (int k = 0; k < bsse_pkg::NUM_SETS; k++) begin
                len_reg[k] <= '0;
            end
        end else begin
            siu_reg <= siu_next;
            if (cmd.load || cmd.found_clr) begin
                found_reg <= 1'b0;
            end else if (cmd.found_set) begin
                found_reg <= 1'b1;
            end
            if (cmd.load) begin
                pend_valid_reg <= 1'b0;
            end else if (cmd.pend_ld) begin
                pend_valid_reg <= 1'b1;
            end
            if (cmd.ins_len) begin
                len_reg[a_reg] <= bsse_pkg::LEN_W'(la_reg + 1'b1);
            end
            if (cmd.commit) begin
                len_reg[siu_reg[bsse_pkg::SET_W-1:0]] <= n_reg;
            end
            // close the gap: every later set moves down one slot
            if (cmd.remove) begin
                for (int k = 0; k < bsse_pkg::NUM_SETS; k++) begin
                    if (k >= int'(a_reg)) begin
                        if (k < bsse_pkg::NUM_SETS - 1 && k + 1 < int'(siu_reg)) begin
                            len_reg[k] <= len_reg[(k + 1) % bsse_pkg::NUM_SETS];
                        end else begin
                            len_reg[k] <= '0;
                        end
                    end
                end
            end
        end
    end

    // counters and request payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= bsse_pkg::kind_t'(s_kind);
            a_reg    <= s_set_a;
            b_reg    <= s_set_b;
            val_reg  <= s_value;
        end
        if (cmd.la_ld) begin
            la_reg <= len_rd;
        end
        if (cmd.lb_ld) begin
            lb_reg <= len_rd;
        end
        if (cmd.hold_ld) begin
            hold_reg <= rdata;
        end
        if (cmd.pend_ld) begin
            pend_idx_reg <= i_reg[bsse_pkg::SET_W-1:0];
            pend_len_reg <= len_rd;
        end
        if (cmd.load) begin
            i_reg <= '0;
        end else if (cmd.i_set_a) begin
            i_reg <= bsse_pkg::CNT_W'(a_reg);
        end else if (cmd.i_inc) begin
            i_reg <= i_plus1;
        end
        if (cmd.load || cmd.j_clr) begin
            j_reg <= '0;
        end else if (cmd.j_inc) begin
            j_reg <= j_reg + 1'b1;
        end
        if (cmd.load) begin
            n_reg <= '0;
        end else if (cmd.n_inc) begin
            n_reg <= n_reg + 1'b1;
        end
    end

    always_comb begin
        unique case (cmd.em_idx)
            bsse_pkg::IX_ZERO: em_idx = '0;
            bsse_pkg::IX_A:    em_idx = a_reg;
            bsse_pkg::IX_BAD:  em_idx = sts.bad_a ? a_reg : b_reg;
            bsse_pkg::IX_SIU:  em_idx = siu_reg[bsse_pkg::SET_W-1:0];
            bsse_pkg::IX_PEND: em_idx = pend_idx_reg;
            default:           em_idx = '0;
        endcase
        unique case (cmd.em_len)
            bsse_pkg::LN_ZERO:   em_len = '0;
            bsse_pkg::LN_LA:     em_len = la_reg;
            bsse_pkg::LN_LA_INC: em_len = bsse_pkg::LEN_W'(la_reg + 1'b1);
            bsse_pkg::LN_N:      em_len = n_reg;
            bsse_pkg::LN_PEND:   em_len = pend_len_reg;
            default:             em_len = '0;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_status_reg <= cmd.em_status;
            m_idx_reg    <= em_idx;
            m_elem_reg   <= cmd.em_elem ? rdata : '0;
            m_len_reg    <= em_len;
            m_last_reg   <= cmd.em_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_set_index = m_idx_reg;
    assign m_element   = m_elem_reg;
    assign m_length    = m_len_reg;
    assign m_last      = m_last_reg;

`ifndef SYNTH
    a_siu_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        siu_reg <= bsse_pkg::SIU_W'(bsse_pkg::NUM_SETS))
        else $error("set count beyond capacity");
    a_commit_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (n_reg <= bsse_pkg::LEN_W'(bsse_pkg::SET_CAP) && !sts.full))
        else $error("new set committed without room");
    a_emit_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid_reg)
        else $error("issued result not presented");
`endif

endmodule
